/* rtl/core/qdse_pkg.sv */
// Shared types and constants of the quadrature decade step encoder.
`timescale 1ns / 1ps

package qdse_pkg;

   // Item operation codes.
   localparam logic [1:0] OP_PIN   = 2'd0;
   localparam logic [1:0] OP_SHORT = 2'd1;
   localparam logic [1:0] OP_LONG  = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_MIN_POS  = 3'd0;
   localparam logic [2:0] CSR_MAX_POS  = 3'd1;
   localparam logic [2:0] CSR_DEBOUNCE = 3'd2;
   localparam logic [2:0] CSR_INVERT   = 3'd3;
   localparam logic [2:0] CSR_SPEED    = 3'd4;

   // Reset values of the registers and of the encoder state.
   localparam logic signed [31:0] MIN_POS_RST  = 32'sd0;
   localparam logic signed [31:0] MAX_POS_RST  = 32'sd125000000;
   localparam logic [15:0]        DEBOUNCE_RST = 16'd50;
   localparam logic [9:0]         SPEED_RST    = 10'd1;
   localparam logic signed [31:0] POS_RST      = 32'sd10;
   localparam logic [19:0]        STEP_RST     = 20'd10;

   // Decade step wrap point and a full detent of the phase counter.
   localparam logic [23:0]       STEP_WRAP      = 24'd10000000;
   localparam logic signed [3:0] FULL_PHASE     = 4'sd4;
   localparam logic signed [3:0] NEG_FULL_PHASE = -4'sd4;

   // Controller states, one-hot.
   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_EVAL = 8'b0000_0010,
      S_MUL  = 8'b0000_0100,
      S_ADD  = 8'b0000_1000,
      S_DIV  = 8'b0001_0000,
      S_FIX  = 8'b0010_0000,
      S_CHK  = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic eval;
      logic mul;
      logic add;
      logic div_step;
      logic fix;
      logic check;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] op;
      logic       div_last;
   } status_type;

endpackage

/* rtl/core/qdse_ctrl.sv */
// Controller state machine of the quadrature decade step encoder.
`timescale 1ns / 1ps

module qdse_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  qdse_pkg::status_type status,
   output qdse_pkg::cmd_type    cmd
);
   import qdse_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            case (status.op)
               OP_PIN:  state_in = S_MUL;
               OP_LONG: state_in = S_DIV;
               default: state_in = S_DONE;
            endcase
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            state_in = S_CHK;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            cmd.fix  = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            cmd.check = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // The output register holds a beat until the receiver takes it.
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/core/qdse_datapath.sv */
// Datapath of the quadrature decade step encoder: registers, phase logic and divider.
`timescale 1ns / 1ps

module qdse_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  qdse_pkg::cmd_type     cmd,
   output qdse_pkg::status_type  status,
   input  logic [1:0]           req_op,
   input  logic                 req_pin_a,
   input  logic                 req_pin_b,
   input  logic [31:0]          req_now_us,
   input  logic                 csr_write_en,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   output logic signed [31:0]   rsp_position,
   output logic                 rsp_moved,
   output logic [19:0]          rsp_step_size
);
   import qdse_pkg::*;

   // Configuration registers.
   logic signed [31:0] min_ff, min_in;
   logic signed [31:0] max_ff, max_in;
   logic [15:0]        deb_ff, deb_in;
   logic               inv_ff, inv_in;
   logic [9:0]         mult_ff, mult_in;

   // Encoder state.
   logic signed [3:0]  phase_ff, phase_in;
   logic [31:0]        last_ff, last_in;
   logic signed [31:0] pos_ff, pos_in;
   logic [19:0]        step_ff, step_in;
   logic               moved_ff, moved_in;

   // Item and working registers.
   logic [1:0]         op_ff, op_in;
   logic               a_ff, a_in;
   logic               b_ff, b_in;
   logic [31:0]        now_ff, now_in;
   logic               try_ff, try_in;
   logic               dir_neg_ff, dir_neg_in;
   logic [29:0]        prod_ff, prod_in;
   logic signed [33:0] cand_ff, cand_in;
   logic [31:0]        mag_ff, mag_in;
   logic [19:0]        rem_ff, rem_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               neg_ff, neg_in;

   // Output register payload.
   logic signed [31:0] rsp_pos_ff, rsp_pos_in;
   logic               rsp_moved_ff, rsp_moved_in;
   logic [19:0]        rsp_step_ff, rsp_step_in;

   // Combinational helpers.
   logic [31:0]        elapsed;
   logic               pass;
   logic signed [3:0]  p1, p2, p3, p4;
   logic               fired;
   logic [23:0]        step_x10;
   logic [23:0]        step_wrapped;
   logic [19:0]        divisor;
   logic [20:0]        trial;
   logic               trial_ge;
   logic signed [33:0] pos_wide;
   logic signed [33:0] min_wide;
   logic signed [33:0] max_wide;
   logic               in_bounds;

   // Debounce window and the four ordered phase rules.
   always_comb begin
      elapsed = now_ff - last_ff;
      pass    = (elapsed >= {16'd0, deb_ff});
      fired   = 1'b0;
      p1      = phase_ff;
      if ((phase_ff == 4'sd0 && !a_ff && b_ff) || (phase_ff == 4'sd2 && a_ff && !b_ff)) begin
         p1    = phase_ff + 4'sd1;
         fired = 1'b1;
      end
      p2 = p1;
      if ((p1 == -4'sd1 && !a_ff && !b_ff) || (p1 == -4'sd3 && a_ff && b_ff)) begin
         p2    = p1 - 4'sd1;
         fired = 1'b1;
      end
      p3 = p2;
      if ((p2 == 4'sd1 && !a_ff && !b_ff) || (p2 == 4'sd3 && a_ff && b_ff)) begin
         p3    = p2 + 4'sd1;
         fired = 1'b1;
      end
      p4 = p3;
      if ((p3 == 4'sd0 && a_ff && !b_ff) || (p3 == -4'sd2 && !a_ff && b_ff)) begin
         p4    = p3 - 4'sd1;
         fired = 1'b1;
      end
   end

   // Next decade step: ten times the step, wrapped at ten million.
   always_comb begin
      step_x10 = {1'b0, step_ff, 3'b000} + {3'b000, step_ff, 1'b0};
      if (step_x10 >= STEP_WRAP) begin
         step_wrapped = step_x10 - STEP_WRAP;
      end else begin
         step_wrapped = step_x10;
      end
   end

   // One restoring division step on the position magnitude.
   always_comb begin
      divisor  = (step_ff == 20'd0) ? 20'd1 : step_ff;
      trial    = {rem_ff, mag_ff[31]};
      trial_ge = (trial >= {1'b0, divisor});
   end

   // Bounds check on the candidate position.
   always_comb begin
      pos_wide  = {{2{pos_ff[31]}}, pos_ff};
      min_wide  = {{2{min_ff[31]}}, min_ff};
      max_wide  = {{2{max_ff[31]}}, max_ff};
      in_bounds = (cand_ff >= min_wide) && (cand_ff <= max_wide);
   end

   // Register next values.
   always_comb begin
      min_in       = min_ff;
      max_in       = max_ff;
      deb_in       = deb_ff;
      inv_in       = inv_ff;
      mult_in      = mult_ff;
      phase_in     = phase_ff;
      last_in      = last_ff;
      pos_in       = pos_ff;
      step_in      = step_ff;
      moved_in     = moved_ff;
      op_in        = op_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      now_in       = now_ff;
      try_in       = try_ff;
      dir_neg_in   = dir_neg_ff;
      prod_in      = prod_ff;
      cand_in      = cand_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_moved_in = rsp_moved_ff;
      rsp_step_in  = rsp_step_ff;

      // Configuration writes.
      if (csr_write_en) begin
         case (csr_index)
            CSR_MIN_POS:  min_in  = csr_wdata;
            CSR_MAX_POS:  max_in  = csr_wdata;
            CSR_DEBOUNCE: deb_in  = csr_wdata[15:0];
            CSR_INVERT:   inv_in  = csr_wdata[0];
            CSR_SPEED:    mult_in = csr_wdata[9:0];
            default: ;
         endcase
      end

      // Capture the accepted beat.
      if (cmd.load_req) begin
         op_in  = req_op;
         a_in   = req_pin_a;
         b_in   = req_pin_b;
         now_in = req_now_us;
      end

      // First work cycle: phase update, step change or divider setup.
      if (cmd.eval) begin
         moved_in = 1'b0;
         try_in   = 1'b0;
         case (op_ff)
            OP_PIN: begin
               if (pass) begin
                  if (fired) begin
                     last_in = now_ff;
                  end
                  try_in     = (p4 == FULL_PHASE) || (p4 == NEG_FULL_PHASE);
                  dir_neg_in = p4[3] ^ inv_ff;
                  if (a_ff && b_ff && p4 != 4'sd0) begin
                     phase_in = 4'sd0;
                  end else begin
                     phase_in = p4;
                  end
               end
            end
            OP_SHORT: begin
               step_in = (step_wrapped == 24'd0) ? 20'd1 : step_wrapped[19:0];
            end
            OP_LONG: begin
               neg_in = pos_ff[31];
               mag_in = pos_ff[31] ? (~pos_ff + 32'd1) : pos_ff;
               rem_in = 20'd0;
               cnt_in = 5'd31;
            end
            default: ;
         endcase
      end

      // Step size times speed factor.
      if (cmd.mul) begin
         prod_in = {10'd0, step_ff} * {20'd0, mult_ff};
      end

      // Candidate position after a full detent.
      if (cmd.add) begin
         if (dir_neg_ff) begin
            cand_in = pos_wide - {4'd0, prod_ff};
         end else begin
            cand_in = pos_wide + {4'd0, prod_ff};
         end
      end

      // One quotient bit per cycle; only the remainder is kept.
      if (cmd.div_step) begin
         rem_in = trial_ge ? 20'(trial - {1'b0, divisor}) : trial[19:0];
         mag_in = {mag_ff[30:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
      end

      // Truncate toward zero by removing the remainder.
      if (cmd.fix) begin
         try_in = 1'b1;
         if (neg_ff) begin
            cand_in = pos_wide + {14'd0, rem_ff};
         end else begin
            cand_in = pos_wide - {14'd0, rem_ff};
         end
      end

      // Keep the candidate only inside the bounds.
      if (cmd.check && try_ff && in_bounds) begin
         pos_in   = cand_ff[31:0];
         moved_in = 1'b1;
      end

      if (cmd.load_rsp) begin
         rsp_pos_in   = pos_ff;
         rsp_moved_in = moved_ff;
         rsp_step_in  = step_ff;
      end
   end

   // Configuration, control and encoder state.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= MIN_POS_RST;
         max_ff   <= MAX_POS_RST;
         deb_ff   <= DEBOUNCE_RST;
         inv_ff   <= 1'b0;
         mult_ff  <= SPEED_RST;
         phase_ff <= 4'sd0;
         last_ff  <= 32'd0;
         pos_ff   <= POS_RST;
         step_ff  <= STEP_RST;
         moved_ff <= 1'b0;
         try_ff   <= 1'b0;
         cnt_ff   <= 5'd0;
      end else begin
         min_ff   <= min_in;
         max_ff   <= max_in;
         deb_ff   <= deb_in;
         inv_ff   <= inv_in;
         mult_ff  <= mult_in;
         phase_ff <= phase_in;
         last_ff  <= last_in;
         pos_ff   <= pos_in;
         step_ff  <= step_in;
         moved_ff <= moved_in;
         try_ff   <= try_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      now_ff       <= now_in;
      dir_neg_ff   <= dir_neg_in;
      prod_ff      <= prod_in;
      cand_ff      <= cand_in;
      mag_ff       <= mag_in;
      rem_ff       <= rem_in;
      neg_ff       <= neg_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_moved_ff <= rsp_moved_in;
      rsp_step_ff  <= rsp_step_in;
   end

   assign status.op       = op_ff;
   assign status.div_last = (cnt_ff == 5'd0);

   assign rsp_position  = rsp_pos_ff;
   assign rsp_moved     = rsp_moved_ff;
   assign rsp_step_size = rsp_step_ff;

endmodule

/* rtl/core/quadrature_decade_step_encoder_top.sv */
// Top level of the quadrature decade step encoder.
`timescale 1ns / 1ps
//
// Usage: each req beat carries an op (pin sample, short click or long click),
// the two encoder pin levels and a microsecond timestamp. Each accepted beat
// yields exactly one rsp beat with the position, a moved flag and the current
// decade step. The csr port writes the position bounds, debounce time, direction
// invert and speed factor, one register per cycle with csr_write_en.
// After req acceptance, a short click or an unused op passes the states EVAL and
// DONE; a pin sample EVAL, MUL, ADD, CHK and DONE; a long click EVAL, DIV, FIX,
// CHK and DONE. The long click runs a one-bit-per-cycle restoring divider over
// the 32-bit position magnitude in DIV. One beat is in work at a time; req_ready
// rises in the same cycle as rsp_valid, so a new beat waits for the last one.
// A finished result waits in the output register while the receiver stalls;
// the next beat may be accepted and worked on, and its result is held back
// until the waiting beat is taken.
// Reset clears the state machine, the output valid, the encoder state (phase 0,
// position 10, step 10) and the configuration to its default values.
//
module quadrature_decade_step_encoder_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic               req_pin_a,
   input  logic               req_pin_b,
   input  logic [31:0]        req_now_us,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_position,
   output logic               rsp_moved,
   output logic [19:0]        rsp_step_size,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import qdse_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencing of each beat.
   qdse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // State, arithmetic and configuration.
   qdse_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_op        (req_op),
      .req_pin_a     (req_pin_a),
      .req_pin_b     (req_pin_b),
      .req_now_us    (req_now_us),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_position  (rsp_position),
      .rsp_moved     (rsp_moved),
      .rsp_step_size (rsp_step_size)
   );

   // A reported step is never zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_step_size != 20'd0))
      else $error("decade step reported as zero");

   // An accepted beat closes the input until its work is done.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input open while a beat is in work");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // A new result loads only while the controller finishes a beat.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> (rsp_valid && req_ready))
      else $error("result load out of step with the controller");

endmodule

/* tb/sv/quadrature_decade_step_encoder_top_test.sv */
// Self-checking testbench of the quadrature decade step encoder top level.
`timescale 1ns / 1ps

module quadrature_decade_step_encoder_top_test;
   import qdse_pkg::*;

   // The block ignores the fourth op code; the package leaves it unnamed.
   localparam logic [1:0] OP_UNUSED       = 2'd3;
   localparam int         ITEMS_PER_PHASE = 320;
   localparam longint     POS_TOP         = 64'sd2147483647;
   localparam longint     POS_BOTTOM      = -64'sd2147483648;

   typedef struct packed {
      logic signed [31:0] position;
      logic               moved;
      logic [19:0]        step_size;
   } enc_result_type;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_ready;
   logic [1:0]         req_op        = OP_PIN;
   logic               req_pin_a     = 1'b0;
   logic               req_pin_b     = 1'b0;
   logic [31:0]        req_now_us    = 32'd0;
   logic               rsp_valid;
   logic               rsp_ready     = 1'b0;
   logic signed [31:0] rsp_position;
   logic               rsp_moved;
   logic [19:0]        rsp_step_size;
   logic               csr_write_en  = 1'b0;
   logic [2:0]         csr_index     = CSR_MIN_POS;
   logic [31:0]        csr_wdata     = 32'd0;

   // Register copies and encoder state of the predictor.
   logic signed [31:0] cfg_min         = MIN_POS_RST;
   logic signed [31:0] cfg_max         = MAX_POS_RST;
   logic [15:0]        cfg_debounce    = DEBOUNCE_RST;
   logic               cfg_invert      = 1'b0;
   logic [9:0]         cfg_speed       = SPEED_RST;
   int                 enc_phase       = 0;
   logic [31:0]        enc_last_change = 32'd0;
   logic signed [31:0] enc_pos         = POS_RST;
   logic [19:0]        enc_step        = STEP_RST;

   enc_result_type expected_results[$];
   enc_result_type rsp_expected;
   logic [31:0] enc_clock_us    = 32'd0;
   int          errors          = 0;
   int          items_sent      = 0;
   int          results_checked = 0;
   int          moves_seen      = 0;
   int          tx_burst        = 0;
   int          rx_burst        = 0;
   int          rx_hold         = 0;

   quadrature_decade_step_encoder_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_pin_a    (req_pin_a),
      .req_pin_b    (req_pin_b),
      .req_now_us   (req_now_us),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_position (rsp_position),
      .rsp_moved    (rsp_moved),
      .rsp_step_size(rsp_step_size),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // Draw a random wait, with occasional stretches of no waiting at all.
   function automatic int draw_wait(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 6);
   endfunction

   function automatic bit in_bounds(input longint cand);
      return cand >= longint'(cfg_min) && cand <= longint'(cfg_max);
   endfunction

   function automatic logic signed [31:0] bound32(input longint v);
      if (v > POS_TOP) return 32'sh7FFF_FFFF;
      if (v < POS_BOTTOM) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // Advance the encoder state by one beat and produce the result it must report.
   task automatic predict_encoder(input logic [1:0] op, input logic pin_a, input logic pin_b,
                                  input logic [31:0] now, output enc_result_type res);
      logic [31:0] elapsed;
      logic [31:0] step_next;
      longint      span;
      longint      cand;
      longint      divisor;
      bit          moved;
      moved = 1'b0;
      case (op)
         OP_PIN: begin
            elapsed = now - enc_last_change;
            if (elapsed >= 32'(cfg_debounce)) begin
               // The four transition rules are applied in order on the running phase.
               if ((enc_phase == 0 && !pin_a && pin_b) || (enc_phase == 2 && pin_a && !pin_b)) begin
                  enc_phase += 1;
                  enc_last_change = now;
               end
               if ((enc_phase == -1 && !pin_a && !pin_b) || (enc_phase == -3 && pin_a && pin_b)) begin
                  enc_phase -= 1;
                  enc_last_change = now;
               end
               if ((enc_phase == 1 && !pin_a && !pin_b) || (enc_phase == 3 && pin_a && pin_b)) begin
                  enc_phase += 1;
                  enc_last_change = now;
               end
               if ((enc_phase == 0 && pin_a && !pin_b) || (enc_phase == -2 && !pin_a && pin_b)) begin
                  enc_phase -= 1;
                  enc_last_change = now;
               end
               // A full detent moves the position by the scaled step if it stays in bounds.
               if (enc_phase == 4 || enc_phase == -4) begin
                  span = longint'(enc_step) * longint'(cfg_speed);
                  if ((enc_phase > 0) ^ cfg_invert)
                     cand = longint'(enc_pos) + span;
                  else
                     cand = longint'(enc_pos) - span;
                  moved = in_bounds(cand);
                  if (moved)
                     enc_pos = cand[31:0];
               end
               if (pin_a && pin_b && enc_phase != 0)
                  enc_phase = 0;
            end
         end
         OP_SHORT: begin
            step_next = (32'(enc_step) * 32'd10) % 32'(STEP_WRAP);
            enc_step = (step_next == 32'd0) ? 20'd1 : step_next[19:0];
         end
         OP_LONG: begin
            // Truncate toward zero to a multiple of the step.
            divisor = (enc_step == 20'd0) ? 64'sd1 : longint'(enc_step);
            cand = longint'(enc_pos) - (longint'(enc_pos) % divisor);
            moved = in_bounds(cand);
            if (moved)
               enc_pos = cand[31:0];
         end
         default: begin
         end
      endcase
      res.position  = enc_pos;
      res.moved     = moved;
      res.step_size = enc_step;
   endtask

   // Present one beat after a random gap and hold it until it is accepted.
   task automatic send_beat(input logic [1:0] op, input logic pin_a, input logic pin_b,
                            input logic [31:0] now);
      int             gap;
      enc_result_type predicted;
      gap = draw_wait(tx_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_op     <= op;
      req_pin_a  <= pin_a;
      req_pin_b  <= pin_b;
      req_now_us <= now;
      do @(posedge clock); while (!req_ready);
      predict_encoder(op, pin_a, pin_b, now, predicted);
      expected_results.push_back(predicted);
      items_sent++;
   endtask

   // Send a pin sample after moving the microsecond time forward. A rough sample
   // draws its gap at random and sometimes lands inside the debounce window.
   task automatic sample_pins(input logic pin_a, input logic pin_b, input bit rough);
      int unsigned span;
      span = 2 * cfg_debounce + 8;
      if (!rough)
         enc_clock_us += 32'(cfg_debounce) + 32'd1;
      else if ($urandom_range(0, 6) != 0)
         enc_clock_us += 32'(cfg_debounce) + $urandom_range(0, span);
      else
         enc_clock_us += $urandom_range(0, cfg_debounce);
      send_beat(OP_PIN, pin_a, pin_b, enc_clock_us);
   endtask

   // One full detent: clockwise goes 01, 00, 10, 11; the other way 10, 00, 01, 11.
   task automatic turn_detent(input bit ccw, input bit rough);
      sample_pins(ccw, !ccw, rough);
      sample_pins(1'b0, 1'b0, rough);
      sample_pins(!ccw, ccw, rough);
      sample_pins(1'b1, 1'b1, rough);
   endtask

   // Stop sending and wait until every expected result has been taken.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_MIN_POS:  cfg_min = value;
         CSR_MAX_POS:  cfg_max = value;
         CSR_DEBOUNCE: cfg_debounce = value[15:0];
         CSR_INVERT:   cfg_invert = value[0];
         CSR_SPEED:    cfg_speed = value[9:0];
         default: begin
         end
      endcase
   endtask

   task automatic configure(input logic signed [31:0] min_pos, input logic signed [31:0] max_pos,
                            input logic [15:0] debounce, input logic invert,
                            input logic [9:0] speed);
      wait_idle();
      write_reg(CSR_MIN_POS, min_pos);
      write_reg(CSR_MAX_POS, max_pos);
      write_reg(CSR_DEBOUNCE, {16'd0, debounce});
      write_reg(CSR_INVERT, {31'd0, invert});
      write_reg(CSR_SPEED, {22'd0, speed});
   endtask

   // Bounds that enclose the current position by the given margin on each side.
   task automatic set_window(input int unsigned half, input logic [15:0] debounce,
                             input logic invert, input logic [9:0] speed);
      configure(bound32(longint'(enc_pos) - longint'(half)),
                bound32(longint'(enc_pos) + longint'(half)), debounce, invert, speed);
   endtask

   // Mostly well-formed detents with random timing, plus stray samples,
   // aborted turns, button beats, the unused op and jumps in time.
   task automatic run_random_phase(input int count);
      int start;
      int pick;
      bit ccw;
      start = items_sent;
      enc_clock_us = $urandom();
      while (items_sent - start < count) begin
         pick = $urandom_range(0, 99);
         ccw  = 1'($urandom_range(0, 1));
         if (pick < 58)
            turn_detent(ccw, 1'b1);
         else if (pick < 70)
            sample_pins(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
         else if (pick < 78) begin
            sample_pins(ccw, !ccw, 1'b1);
            if ($urandom_range(0, 1))
               sample_pins(1'b0, 1'b0, 1'b1);
            sample_pins(1'b1, 1'b1, 1'b1);
         end else if (pick < 86)
            send_beat(OP_SHORT, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
         else if (pick < 93)
            send_beat(OP_LONG, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
         else if (pick < 96)
            send_beat(OP_UNUSED, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      $urandom());
         else begin
            enc_clock_us = $urandom();
            sample_pins(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
         end
      end
   endtask

   // Defaults after reset: the unused op, a long click and a short click.
   task automatic test_reset_state();
      send_beat(OP_UNUSED, 1'b1, 1'b1, 32'hFFFF_FFFF);
      send_beat(OP_LONG, 1'b1, 1'b0, 32'd0);
      send_beat(OP_SHORT, 1'b0, 1'b1, 32'h5A5A_5A5A);
   endtask

   // Detents both ways, a sample inside the debounce window and an aborted turn.
   task automatic test_rotation();
      enc_clock_us = 32'd1000;
      turn_detent(1'b0, 1'b0);
      turn_detent(1'b1, 1'b0);
      send_beat(OP_PIN, 1'b0, 1'b1, enc_clock_us + 32'd1);
      sample_pins(1'b1, 1'b0, 1'b0);
      sample_pins(1'b1, 1'b1, 1'b0);
   endtask

   // The microsecond counter wraps between samples; the third is one window after the first.
   task automatic test_time_wrap();
      send_beat(OP_PIN, 1'b0, 1'b1, 32'hFFFF_FFF0);
      send_beat(OP_PIN, 1'b0, 1'b0, 32'h0000_0010);
      send_beat(OP_PIN, 1'b0, 1'b0, 32'h0000_0022);
      enc_clock_us = 32'h0000_0022;
      sample_pins(1'b1, 1'b0, 1'b0);
      sample_pins(1'b1, 1'b1, 1'b0);
   endtask

   // A zero speed factor writes the unchanged position; reversed bounds refuse all writes.
   task automatic test_register_cases();
      configure(MIN_POS_RST, MAX_POS_RST, 16'd0, 1'b1, 10'd0);
      turn_detent(1'b0, 1'b0);
      configure(32'sd5, 32'sd4, 16'd0, 1'b0, 10'd1);
      send_beat(OP_LONG, 1'b0, 1'b0, 32'd0);
   endtask

   task automatic test_random_wide_window();
      set_window($urandom_range(0, 100000000), 16'($urandom_range(0, 200)), 1'b0, 10'd1);
      run_random_phase(ITEMS_PER_PHASE);
   endtask

   task automatic test_random_extremes();
      configure(32'sh8000_0000, 32'sh7FFF_FFFF, 16'd0, 1'b1, 10'd1023);
      run_random_phase(ITEMS_PER_PHASE);
   endtask

   task automatic test_random_narrow_window();
      set_window($urandom_range(0, 5000), 16'($urandom_range(0, 100)),
                 1'($urandom_range(0, 1)), 10'($urandom_range(1, 20)));
      run_random_phase(ITEMS_PER_PHASE);
   endtask

   task automatic test_random_reversed_bounds();
      configure(32'sd1000, -32'sd1000, 16'($urandom_range(0, 100)), 1'($urandom_range(0, 1)),
                10'($urandom_range(1, 1000)));
      run_random_phase(ITEMS_PER_PHASE);
   endtask

   task automatic test_random_slow_zero_speed();
      configure(32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0, 10'd0);
      run_random_phase(ITEMS_PER_PHASE);
   endtask

   task automatic test_random_registers();
      set_window($urandom(), 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                 10'($urandom_range(0, 1023)));
      run_random_phase(ITEMS_PER_PHASE / 2);
      configure($urandom(), $urandom(), 16'($urandom_range(0, 65535)),
                1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)));
      run_random_phase(ITEMS_PER_PHASE / 2);
   endtask

   // Result side: random stalls, and each taken beat is compared with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: result with nothing expected, position %0d moved %0b step %0d",
                        $time, rsp_position, rsp_moved, rsp_step_size);
            end else begin
               rsp_expected = expected_results.pop_front();
               results_checked++;
               if (rsp_moved)
                  moves_seen++;
               if (rsp_position !== rsp_expected.position) begin
                  errors++;
                  $display("%0t: position mismatch, expected %0d, actual %0d",
                           $time, rsp_expected.position, rsp_position);
               end
               if (rsp_moved !== rsp_expected.moved) begin
                  errors++;
                  $display("%0t: moved mismatch, expected %0b, actual %0b",
                           $time, rsp_expected.moved, rsp_moved);
               end
               if (rsp_step_size !== rsp_expected.step_size) begin
                  errors++;
                  $display("%0t: step_size mismatch, expected %0d, actual %0d",
                           $time, rsp_expected.step_size, rsp_step_size);
               end
            end
            rx_hold = draw_wait(rx_burst);
         end else if (rsp_valid && rx_hold > 0) begin
            rx_hold--;
         end
         rsp_ready <= (rx_hold == 0);
      end
   end

   // Test sequence.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_rotation();
      test_time_wrap();
      test_register_cases();
      test_random_wide_window();
      test_random_extremes();
      test_random_narrow_window();
      test_random_reversed_bounds();
      test_random_slow_zero_speed();
      test_random_registers();
      wait_idle();
      repeat (40) @(posedge clock);
      $display("Sent %0d beats: detents both ways, debounce and time wrap, clicks, unused op,",
               items_sent);
      $display("over ten register settings; %0d results checked, %0d with a position write.",
               results_checked, moves_seen);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("Timed out with %0d results still expected.", expected_results.size());
      $display("status: fail");
      $finish;
   end

endmodule
